// ===== rtl/signed_binary_to_decimal_ascii_unit_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the signed binary to decimal ASCII unit
// Shared concurrent assertion forms, clocked and reset-gated.
// ----------------------------------------------------------------------------
`ifndef SIGNED_BINARY_TO_DECIMAL_ASCII_UNIT_DEFINES_SVH
`define SIGNED_BINARY_TO_DECIMAL_ASCII_UNIT_DEFINES_SVH

// Same-cycle implication.
`define SBDA_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sbda assertion failed");

// Next-cycle implication.
`define SBDA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sbda assertion failed");

`endif

// ===== rtl/sbda_pkg.sv =====
// ----------------------------------------------------------------------------
// sbda_pkg
// Constants shared by the signed binary to decimal ASCII unit.
// ----------------------------------------------------------------------------
package sbda_pkg;

  localparam int DefaultInputBits = 32;
  localparam int FifoDepth        = 2;
  // Input bits consumed per shift-add-3 step.
  localparam int BcdStepBits      = 4;

  localparam logic [7:0] CharMinus = 8'd45;
  localparam logic [7:0] CharZero  = 8'd48;

endpackage

// ===== rtl/sbda_front.sv =====
// ----------------------------------------------------------------------------
// sbda_front
// Accepts input requests, splits each value into sign and magnitude.
// ----------------------------------------------------------------------------
module sbda_front import sbda_pkg::*; #(
  parameter int INPUT_BITS = DefaultInputBits,
  parameter int TDataW     = 8 * ((INPUT_BITS + 7) / 8)
) (
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  input  logic [TDataW-1:0]     s_axis_tdata_i,   // [INPUT_BITS-1:0] value
  output logic                  push_o,
  output logic [INPUT_BITS:0]   push_data_o,      // {neg, magnitude}
  input  logic                  full_i
);

  logic [INPUT_BITS-1:0] raw;
  logic                  neg;
  logic [INPUT_BITS-1:0] mag;

  assign raw = s_axis_tdata_i[INPUT_BITS-1:0];
  assign neg = raw[INPUT_BITS-1];
  // Magnitude in unsigned arithmetic so the most negative value is exact.
  assign mag = neg ? (~raw + {{(INPUT_BITS-1){1'b0}}, 1'b1}) : raw;

  assign s_axis_tready_o = !full_i;
  assign push_o          = s_axis_tvalid_i && !full_i;
  assign push_data_o     = {neg, mag};

endmodule

// ===== rtl/sbda_fifo.sv =====
// ----------------------------------------------------------------------------
// sbda_fifo
// Short queue between the front and back parts.
// ----------------------------------------------------------------------------
module sbda_fifo import sbda_pkg::*; #(
  parameter int DataW = DefaultInputBits + 1,
  parameter int Depth = FifoDepth
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [DataW-1:0] push_data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output logic [DataW-1:0] data_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  logic [DataW-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CntW'(Depth));
  assign valid_o = (count_q != '0);
  assign data_o  = mem_q[rptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  function automatic logic [PtrW-1:0] ptr_inc(logic [PtrW-1:0] p);
    ptr_inc = (p == PtrW'(Depth - 1)) ? '0 : p + PtrW'(1);
  endfunction

  always_comb begin
    wptr_d  = do_push ? ptr_inc(wptr_q) : wptr_q;
    rptr_d  = do_pop ? ptr_inc(rptr_q) : rptr_q;
    count_d = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= push_data_i;
    end
  end

endmodule

// ===== rtl/sbda_back.sv =====
// ----------------------------------------------------------------------------
// sbda_back
// Converts a magnitude to BCD by shift-add-3, then emits the characters.
// ----------------------------------------------------------------------------
module sbda_back import sbda_pkg::*; #(
  parameter int INPUT_BITS = DefaultInputBits
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                fifo_valid_i,
  input  logic [INPUT_BITS:0] fifo_data_i,      // {neg, magnitude}
  output logic                pop_o,
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  output logic [7:0]          m_axis_tdata_o,   // [7:0] char_code
  output logic                m_axis_tlast_o
);

  // Decimal digits of the largest magnitude, 2**(INPUT_BITS-1).
  localparam int NumDigits = ((INPUT_BITS - 1) * 30103) / 100000 + 1;
  localparam int Steps     = (INPUT_BITS + BcdStepBits - 1) / BcdStepBits;
  localparam int PadW      = Steps * BcdStepBits;
  localparam int BcdW      = 4 * NumDigits;
  localparam int IdxW      = (NumDigits > 1) ? $clog2(NumDigits) : 1;
  localparam int StepW     = (Steps > 1) ? $clog2(Steps) : 1;

  typedef enum logic [4:0] {
    StIdle  = 5'b00001,
    StConv  = 5'b00010,
    StFind  = 5'b00100,
    StSign  = 5'b01000,
    StDigit = 5'b10000
  } back_state_e;

  back_state_e      state_q, state_d;
  logic             neg_q;
  logic [PadW-1:0]  shift_q, shift_d;
  logic [BcdW-1:0]  bcd_q, bcd_d;
  logic [StepW-1:0] step_q;
  logic [IdxW-1:0]  idx_q, lead;
  logic             out_valid_q, out_valid_d;
  logic [7:0]       out_char_q;
  logic             out_last_q;
  logic             can_load;
  logic             digit_done;
  logic             load_item;
  logic [3:0]       cur_digit;

  assign can_load   = !out_valid_q || m_axis_tready_i;
  assign digit_done = (state_q == StDigit) && can_load && (idx_q == '0);
  assign load_item  = fifo_valid_i && ((state_q == StIdle) || digit_done);
  assign pop_o      = load_item;
  assign cur_digit  = bcd_q[{idx_q, 2'b00} +: 4];

  // Shift-add-3 over BcdStepBits input bits per cycle.
  always_comb begin
    bcd_d   = bcd_q;
    shift_d = shift_q;
    for (int b = 0; b < BcdStepBits; b++) begin
      for (int d = 0; d < NumDigits; d++) begin
        if (bcd_d[4*d +: 4] >= 4'd5) begin
          bcd_d[4*d +: 4] = bcd_d[4*d +: 4] + 4'd3;
        end
      end
      bcd_d   = {bcd_d[BcdW-2:0], shift_d[PadW-1]};
      shift_d = {shift_d[PadW-2:0], 1'b0};
    end
  end

  // Leading nonzero digit; zero value falls to digit 0.
  always_comb begin
    lead = '0;
    for (int i = 0; i < NumDigits; i++) begin
      if (bcd_q[4*i +: 4] != 4'd0) begin
        lead = IdxW'(i);
      end
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle:  if (load_item) state_d = StConv;
      StConv:  if (step_q == '0) state_d = StFind;
      StFind:  state_d = neg_q ? StSign : StDigit;
      StSign:  if (can_load) state_d = StDigit;
      StDigit: begin
        if (digit_done) begin
          state_d = load_item ? StConv : StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q && !m_axis_tready_i;
    if (can_load && ((state_q == StSign) || (state_q == StDigit))) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_item) begin
      neg_q   <= fifo_data_i[INPUT_BITS];
      shift_q <= PadW'(fifo_data_i[INPUT_BITS-1:0]);
      bcd_q   <= '0;
      step_q  <= StepW'(Steps - 1);
    end else if (state_q == StConv) begin
      shift_q <= shift_d;
      bcd_q   <= bcd_d;
      step_q  <= step_q - StepW'(1);
    end
    if (state_q == StFind) begin
      idx_q <= lead;
    end else if ((state_q == StDigit) && can_load && (idx_q != '0)) begin
      idx_q <= idx_q - IdxW'(1);
    end
    if (can_load && (state_q == StSign)) begin
      out_char_q <= CharMinus;
      out_last_q <= 1'b0;
    end else if (can_load && (state_q == StDigit)) begin
      out_char_q <= CharZero + {4'b0000, cur_digit};
      out_last_q <= (idx_q == '0);
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_char_q;
  assign m_axis_tlast_o  = out_last_q;

endmodule

// ===== rtl/signed_binary_to_decimal_ascii_unit.sv =====
// ----------------------------------------------------------------------------
// signed_binary_to_decimal_ascii_unit
// Signed integer in, decimal ASCII text out, one character per output transfer.
// ----------------------------------------------------------------------------
// Each accepted value leaves as its decimal text, most significant character
// first, with a leading '-' for negative values, no leading zeros, and tlast
// on the final character. The front takes a value whenever its two-entry
// queue has room, so up to two values can wait while the back converts. The
// back runs its shift-add-3 BCD converter (four bits a cycle), then finds the
// leading digit, then emits one character per cycle while the output is
// taken; at 32 bits a value gives 1 to 11 characters. The back takes the next
// value from the queue only as it emits the last character of the current one.
module signed_binary_to_decimal_ascii_unit import sbda_pkg::*; #(
  parameter int INPUT_BITS = DefaultInputBits
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  input  logic [8*((INPUT_BITS+7)/8)-1:0]     s_axis_tdata_i,  // [INPUT_BITS-1:0] value
  output logic                                m_axis_tvalid_o,
  input  logic                                m_axis_tready_i,
  output logic [7:0]                          m_axis_tdata_o,  // [7:0] char_code
  output logic                                m_axis_tlast_o
);

  logic                push;
  logic [INPUT_BITS:0] push_data;
  logic                full;
  logic                pop;
  logic                fifo_valid;
  logic [INPUT_BITS:0] fifo_data;

  sbda_front #(
    .INPUT_BITS (INPUT_BITS)
  ) u_front (
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .push_o          (push),
    .push_data_o     (push_data),
    .full_i          (full)
  );

  sbda_fifo #(
    .DataW (INPUT_BITS + 1),
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (full),
    .pop_i       (pop),
    .valid_o     (fifo_valid),
    .data_o      (fifo_data)
  );

  sbda_back #(
    .INPUT_BITS (INPUT_BITS)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .fifo_valid_i    (fifo_valid),
    .fifo_data_i     (fifo_data),
    .pop_o           (pop),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

endmodule

// ===== rtl/sbda_checker.sv =====
// ----------------------------------------------------------------------------
// sbda_checker
// Port-level checks on the character stream of the ASCII unit.
// ----------------------------------------------------------------------------
`include "signed_binary_to_decimal_ascii_unit_defines.svh"

module sbda_checker import sbda_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       m_axis_tvalid_i,
  input logic       m_axis_tready_i,
  input logic [7:0] m_axis_tdata_i,
  input logic       m_axis_tlast_i
);

  logic at_start_q;
  logic prev_minus_q;
  logic out_take;

  assign out_take = m_axis_tvalid_i && m_axis_tready_i;

  // Track position within the current number's text.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      at_start_q   <= 1'b1;
      prev_minus_q <= 1'b0;
    end else if (out_take) begin
      at_start_q   <= m_axis_tlast_i;
      prev_minus_q <= (m_axis_tdata_i == CharMinus);
    end
  end

  `SBDA_ASSERT_NEXT(a_stall_hold, clk_i, rst_ni, m_axis_tvalid_i && !m_axis_tready_i, m_axis_tvalid_i && $stable(m_axis_tdata_i) && $stable(m_axis_tlast_i))
  `SBDA_ASSERT_NOW(a_char_set, clk_i, rst_ni, m_axis_tvalid_i, (m_axis_tdata_i == CharMinus) || ((m_axis_tdata_i >= CharZero) && (m_axis_tdata_i <= CharZero + 8'd9)))
  `SBDA_ASSERT_NOW(a_minus_not_last, clk_i, rst_ni, m_axis_tvalid_i && (m_axis_tdata_i == CharMinus), !m_axis_tlast_i && at_start_q)
  `SBDA_ASSERT_NOW(a_lone_zero, clk_i, rst_ni, m_axis_tvalid_i && at_start_q && (m_axis_tdata_i == CharZero), m_axis_tlast_i)
  `SBDA_ASSERT_NOW(a_no_zero_after_minus, clk_i, rst_ni, m_axis_tvalid_i && prev_minus_q, m_axis_tdata_i != CharZero)

endmodule

bind signed_binary_to_decimal_ascii_unit sbda_checker u_sbda_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .m_axis_tvalid_i (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_i  (m_axis_tdata_o),
  .m_axis_tlast_i  (m_axis_tlast_o)
);
